// ===== rtl/core/pnmh_pkg.sv =====
package pnmh_pkg;

   // Sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_HOLD     = 4'd1,
      PH_READY1   = 4'd2,
      PH_READY2   = 4'd3,
      PH_NEG1     = 4'd4,
      PH_STROBE   = 4'd5,
      PH_NEG2     = 4'd6,
      PH_NIB_LOW  = 4'd7,
      PH_NIB_HIGH = 4'd8
   } phase_type;

   // Request kinds carried on tuser
   typedef enum logic {
      ACT_TICK  = 1'b0,
      ACT_START = 1'b1
   } action_type;

   // Register indexes
   typedef enum logic [2:0] {
      REG_REQUEST_BYTE = 3'd0,
      REG_BYTE_LIMIT   = 3'd1,
      REG_RESET_HOLD   = 3'd2,
      REG_READY_TO     = 3'd3,
      REG_NEG_TO       = 3'd4,
      REG_STROBE       = 3'd5,
      REG_NIBBLE_TO    = 3'd6
   } reg_index_type;

   // End codes
   typedef enum logic [2:0] {
      END_NONE      = 3'd0,
      END_LIMIT     = 3'd1,
      END_NIB_TO    = 3'd2,
      END_NOT_READY = 3'd3,
      END_NEG1_FAIL = 3'd4,
      END_NEG2_FAIL = 3'd5
   } end_code_type;

   localparam int TIMER_W = 24;
   localparam int COUNT_W = 16;
   localparam int RSP_DATA_W = 48;

   // Control line bits
   localparam logic [4:0] CT_SEL  = 5'h08;
   localparam logic [4:0] CT_INIT = 5'h04;
   localparam logic [4:0] CT_FEED = 5'h02;
   localparam logic [4:0] CT_STB  = 5'h01;
   localparam logic [4:0] CT_NONE = 5'h00;

   // Status line bits and negotiation patterns
   localparam int         ST_BUSY_BIT = 7;
   localparam int         ST_ACK_BIT  = 6;
   localparam logic [7:0] ST_MASK     = 8'hF8;
   localparam logic [7:0] NEG1_WANT   = 8'h38;
   localparam logic [7:0] NEG2_WANT   = 8'h50;

   // Register reset values
   localparam logic [7:0]         RST_REQUEST_BYTE = 8'h04;
   localparam logic [COUNT_W-1:0] RST_BYTE_LIMIT   = 16'd256;
   localparam logic [TIMER_W-1:0] RST_RESET_HOLD   = 24'd50;
   localparam logic [TIMER_W-1:0] RST_READY_TO     = 24'd1000000;
   localparam logic [TIMER_W-1:0] RST_NEG_TO       = 24'd1000000;
   localparam logic [TIMER_W-1:0] RST_STROBE       = 24'd10000;
   localparam logic [TIMER_W-1:0] RST_NIBBLE_TO    = 24'd500000;

endpackage

// ===== rtl/core/parallel_nibble_mode_host_unit.sv =====
// Host side of a 1284 nibble-mode reverse transfer.
// req channel: one request per tick. tuser = action (0 tick with a status
//   sample, 1 start); tdata = status lines (bit7 BUSY, 6 nACK, 5 PE,
//   4 SELECT, 3 nERROR). A start while a sequence runs is ignored.
// rsp channel: exactly one response per request, showing the state after it:
//   control and data line drive, the byte completed on this tick (tuser = 1),
//   byte count, active flag and the end code of the last sequence.
// csr port: plain write (csr_we, csr_addr, csr_wdata); the user writes only
//   while idle, unchecked by the block. Response: registered, valid in the
//   cycle after acceptance. Throughput: one request per cycle unless
//   stalled; the whole sequencer step (one 24-bit increment and compare, a
//   few pattern matches) sits between state and response registers.
// Stall: the response register holds while rsp_tready is low; req_tready
//   is low only while a response waits and is not taken this cycle.
// Reset: synchronous, active high. Sequencer idle, line drive zero, count
//   and end code zero, registers to their defaults, no response pending.
module parallel_nibble_mode_host_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] status_lines
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] control_lines, [12:5] data_lines, [20:13] byte_value,
   // [36:21] bytes_received, [37] active, [40:38] end_code, [47:41] zero
   output logic [pnmh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] byte_valid
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [23:0] csr_wdata
);
   import pnmh_pkg::*;

   // configuration registers
   logic [7:0]         request_byte_ff;
   logic [COUNT_W-1:0] byte_limit_ff;
   logic [TIMER_W-1:0] reset_hold_ff, ready_to_ff, neg_to_ff, strobe_ff, nibble_to_ff;

   // sequencer state
   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [4:0]         control_ff, control_in;
   logic [7:0]         data_ff, data_in;
   logic [3:0]         low_nib_ff, low_nib_in, high_nib_ff, high_nib_in;
   logic               second_ff, second_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   end_code_type       end_ff, end_in;

   // response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff;
   logic                  byte_valid;
   logic [7:0]            byte_value;

   logic               accept, start, tick;
   logic [7:0]         st;
   logic               cond, timeout, limit_hit;
   logic [TIMER_W-1:0] timer_inc, limit_sel;
   logic [COUNT_W-1:0] count_inc;
   logic [3:0]         nib;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (req_tuser == ACT_START);
   assign tick       = accept && (req_tuser == ACT_TICK);
   assign st         = req_tdata;

   assign timer_inc = timer_ff + 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign timeout   = timer_inc >= limit_sel;
   // nibble = {~BUSY, PE, SELECT, nERROR}
   assign nib       = {~st[ST_BUSY_BIT], st[5:3]};

   // per-phase wait condition and timeout limit
   always_comb begin
      cond      = 1'b0;
      limit_sel = nibble_to_ff;
      unique case (phase_ff)
         PH_HOLD: begin
            limit_sel = reset_hold_ff;
         end
         PH_READY1, PH_READY2: begin
            cond      = !st[ST_BUSY_BIT];
            limit_sel = ready_to_ff;
         end
         PH_NEG1: begin
            cond      = (st & ST_MASK) == NEG1_WANT;
            limit_sel = neg_to_ff;
         end
         PH_STROBE: begin
            limit_sel = strobe_ff;
         end
         PH_NEG2: begin
            cond      = (st & ST_MASK) == NEG2_WANT;
            limit_sel = neg_to_ff;
         end
         PH_NIB_LOW: begin
            cond = !st[ST_ACK_BIT];
         end
         PH_NIB_HIGH: begin
            cond = st[ST_ACK_BIT];
         end
         default: begin
            cond = 1'b0;
         end
      endcase
   end

   // byte limit check at the start of each byte (count after this tick)
   assign limit_hit = (phase_ff == PH_NIB_HIGH) ? (count_inc >= byte_limit_ff)
                                                : (count_ff >= byte_limit_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         if (phase_ff == PH_IDLE) begin
            phase_in = PH_HOLD;
         end
      end else if (tick) begin
         unique case (phase_ff)
            PH_IDLE:   phase_in = PH_IDLE;
            PH_HOLD:   if (timeout) phase_in = PH_READY1;
            PH_READY1: begin
               if (cond) phase_in = PH_READY2;
               else if (timeout) phase_in = PH_IDLE;
            end
            PH_READY2: begin
               if (cond) phase_in = PH_NEG1;
               else if (timeout) phase_in = PH_IDLE;
            end
            PH_NEG1: begin
               if (cond) phase_in = PH_STROBE;
               else if (timeout) phase_in = PH_IDLE;
            end
            PH_STROBE: if (timeout) phase_in = PH_NEG2;
            PH_NEG2: begin
               if (cond) phase_in = limit_hit ? PH_IDLE : PH_NIB_LOW;
               else if (timeout) phase_in = PH_IDLE;
            end
            PH_NIB_LOW: begin
               if (cond) phase_in = PH_NIB_HIGH;
               else if (timeout) phase_in = PH_IDLE;
            end
            PH_NIB_HIGH: begin
               if (cond) begin
                  if (!second_ff) phase_in = PH_NIB_LOW;
                  else phase_in = limit_hit ? PH_IDLE : PH_NIB_LOW;
               end else if (timeout) begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      timer_in    = timer_ff;
      control_in  = control_ff;
      data_in     = data_ff;
      low_nib_in  = low_nib_ff;
      high_nib_in = high_nib_ff;
      second_in   = second_ff;
      count_in    = count_ff;
      end_in      = end_ff;
      byte_valid  = 1'b0;
      byte_value  = 8'h00;
      if (start) begin
         if (phase_ff == PH_IDLE) begin
            control_in = CT_SEL | CT_INIT;
            timer_in   = '0;
            count_in   = '0;
            second_in  = 1'b0;
            end_in     = END_NONE;
         end
      end else if (tick && (phase_ff != PH_IDLE)) begin
         // every exit from a wait clears the timer
         timer_in = (cond || timeout) ? '0 : timer_inc;
         case (phase_ff)
            PH_HOLD: if (timeout) control_in = CT_SEL;
            PH_READY1: begin
               if (cond) data_in = request_byte_ff;
               else if (timeout) end_in = END_NOT_READY;
            end
            PH_READY2: begin
               if (cond) control_in = CT_FEED;
               else if (timeout) end_in = END_NOT_READY;
            end
            PH_NEG1: begin
               if (cond) control_in = CT_FEED | CT_STB;
               else if (timeout) end_in = END_NEG1_FAIL;
            end
            PH_STROBE: if (timeout) control_in = CT_NONE;
            PH_NEG2: begin
               if (cond) begin
                  if (limit_hit) begin
                     end_in = END_LIMIT;
                  end else begin
                     second_in  = 1'b0;
                     control_in = CT_FEED;
                  end
               end else if (timeout) begin
                  end_in = END_NEG2_FAIL;
               end
            end
            PH_NIB_LOW: begin
               if (cond) begin
                  if (second_ff) high_nib_in = nib;
                  else low_nib_in = nib;
                  control_in = CT_NONE;
               end else if (timeout) begin
                  end_in = END_NIB_TO;
               end
            end
            PH_NIB_HIGH: begin
               if (cond) begin
                  if (!second_ff) begin
                     second_in  = 1'b1;
                     control_in = CT_FEED;
                  end else begin
                     byte_valid = 1'b1;
                     byte_value = {high_nib_ff, low_nib_ff};
                     count_in   = count_inc;
                     if (limit_hit) begin
                        end_in = END_LIMIT;
                     end else begin
                        second_in  = 1'b0;
                        control_in = CT_FEED;
                     end
                  end
               end else if (timeout) begin
                  end_in = END_NIB_TO;
               end
            end
            default: timer_in = '0;
         endcase
      end
   end

   assign rsp_data_in = {7'b0, end_in, (phase_in != PH_IDLE), count_in, byte_value,
                         data_in, control_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         request_byte_ff <= RST_REQUEST_BYTE;
         byte_limit_ff   <= RST_BYTE_LIMIT;
         reset_hold_ff   <= RST_RESET_HOLD;
         ready_to_ff     <= RST_READY_TO;
         neg_to_ff       <= RST_NEG_TO;
         strobe_ff       <= RST_STROBE;
         nibble_to_ff    <= RST_NIBBLE_TO;
      end else if (csr_we) begin
         case (csr_addr)
            REG_REQUEST_BYTE: request_byte_ff <= csr_wdata[7:0];
            REG_BYTE_LIMIT:   byte_limit_ff   <= csr_wdata[COUNT_W-1:0];
            REG_RESET_HOLD:   reset_hold_ff   <= csr_wdata;
            REG_READY_TO:     ready_to_ff     <= csr_wdata;
            REG_NEG_TO:       neg_to_ff       <= csr_wdata;
            REG_STROBE:       strobe_ff       <= csr_wdata;
            REG_NIBBLE_TO:    nibble_to_ff    <= csr_wdata;
            default: ;  // index outside the register list: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         control_ff  <= CT_NONE;
         data_ff     <= 8'h00;
         low_nib_ff  <= 4'h0;
         high_nib_ff <= 4'h0;
         second_ff   <= 1'b0;
         count_ff    <= '0;
         end_ff      <= END_NONE;
      end else if (accept) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         control_ff  <= control_in;
         data_ff     <= data_in;
         low_nib_ff  <= low_nib_in;
         high_nib_ff <= high_nib_in;
         second_ff   <= second_in;
         count_ff    <= count_in;
         end_ff      <= end_in;
      end
   end

   // response register: loads on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= byte_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // an idle sequencer always has a cleared wait timer
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (timer_ff == '0))
      else $error("wait timer not cleared while idle");

   // nStrobe phase drives FEED and STB
   a_strobe_drive: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STROBE) |-> (control_ff == (CT_FEED | CT_STB)))
      else $error("strobe phase with wrong control drive");

   // a completed second nibble produces a byte response next cycle
   a_byte_out: assert property (@(posedge clock) disable iff (reset)
      (tick && (phase_ff == PH_NIB_HIGH) && second_ff && st[ST_ACK_BIT])
      |=> (rsp_tvalid && rsp_tuser))
      else $error("completed byte not reported");
`endif

endmodule

// ===== tb/tb_parallel_nibble_mode_host_unit.sv =====
`timescale 1ns / 100ps

module tb_parallel_nibble_mode_host_unit;
   import pnmh_pkg::*;

   // Run guard: far above the slowest correct run.
   localparam int CYCLE_LIMIT = 300000;

   // ---------------------------------------------------------------
   // DUT ports, every input known from time zero
   // ---------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;   // [7:0] status_lines
   logic                  req_tuser  = 1'b0;    // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [4:0] control_lines, [12:5] data_lines, [20:13] byte_value,
   // [36:21] bytes_received, [37] active, [40:38] end_code, [47:41] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;            // [0] byte_valid
   logic                  csr_we     = 1'b0;
   logic [2:0]            csr_addr   = 3'd0;
   logic [23:0]           csr_wdata  = 24'd0;

   parallel_nibble_mode_host_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Host model: the sequencer as seen from the bus
   // ---------------------------------------------------------------
   typedef struct packed {
      logic [4:0]  ctrl;
      logic [7:0]  data;
      logic        valid;
      logic [7:0]  value;
      logic [15:0] count;
      logic        active;
      logic [2:0]  ecode;
   } host_view_type;

   host_view_type expected_views[$];

   // register shadow
   logic [7:0]         r_req;
   logic [COUNT_W-1:0] r_limit;
   logic [TIMER_W-1:0] r_hold, r_ready_to, r_neg_to, r_strobe, r_nib_to;

   // sequencer shadow
   phase_type          m_phase;
   end_code_type       m_end;
   logic [TIMER_W-1:0] m_timer;
   logic [4:0]         m_ctrl;
   logic [7:0]         m_data;
   logic [3:0]         m_lo, m_hi;
   logic               m_second;
   logic [COUNT_W-1:0] m_count;

   // bookkeeping
   int  requests_sent  = 0;
   int  rsp_count      = 0;
   int  bytes_seen     = 0;
   int  sequences_run  = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  end_seen[8];
   int  hold_off_cycles = 0;   // receiver hold-off, counted down in its own process
   bit  no_idle = 1'b0;        // quiet stretch: neither side idles

   // A failed sample bumps the wait timer; true once it reaches the limit.
   // Limit zero behaves like one.
   function automatic bit count_miss(input logic [TIMER_W-1:0] lim);
      m_timer = m_timer + 1'b1;
      return m_timer >= lim;
   endfunction

   function automatic void close_sequence(input end_code_type code);
      m_phase = PH_IDLE;
      m_timer = '0;
      m_end   = code;
   endfunction

   // Next byte, or done when the limit is reached (limit zero: no bytes).
   function automatic void start_byte_read();
      if (m_count >= r_limit) begin
         close_sequence(END_LIMIT);
      end else begin
         m_second = 1'b0;
         m_ctrl   = CT_FEED;
         m_phase  = PH_NIB_LOW;
         m_timer  = '0;
      end
   endfunction

   function automatic host_view_type predict_host_step(input action_type act,
                                                       input logic [7:0] st);
      host_view_type v;
      logic [3:0] nib;
      v = '0;
      if (act == ACT_START) begin
         // start is ignored outright while a sequence runs
         if (m_phase == PH_IDLE) begin
            m_ctrl   = CT_SEL | CT_INIT;
            m_phase  = PH_HOLD;
            m_timer  = '0;
            m_count  = '0;
            m_second = 1'b0;
            m_end    = END_NONE;
         end
      end else begin
         case (m_phase)
            PH_HOLD: begin
               if (count_miss(r_hold)) begin
                  m_ctrl  = CT_SEL;
                  m_phase = PH_READY1;
                  m_timer = '0;
               end
            end
            PH_READY1, PH_READY2: begin
               if (!st[ST_BUSY_BIT]) begin
                  m_timer = '0;
                  if (m_phase == PH_READY1) begin
                     m_data  = r_req;
                     m_phase = PH_READY2;
                  end else begin
                     m_ctrl  = CT_FEED;
                     m_phase = PH_NEG1;
                  end
               end else if (count_miss(r_ready_to)) begin
                  close_sequence(END_NOT_READY);
               end
            end
            PH_NEG1: begin
               if ((st & ST_MASK) == NEG1_WANT) begin
                  m_ctrl  = CT_FEED | CT_STB;
                  m_phase = PH_STROBE;
                  m_timer = '0;
               end else if (count_miss(r_neg_to)) begin
                  close_sequence(END_NEG1_FAIL);
               end
            end
            PH_STROBE: begin
               if (count_miss(r_strobe)) begin
                  m_ctrl  = CT_NONE;
                  m_phase = PH_NEG2;
                  m_timer = '0;
               end
            end
            PH_NEG2: begin
               if ((st & ST_MASK) == NEG2_WANT) start_byte_read();
               else if (count_miss(r_neg_to)) close_sequence(END_NEG2_FAIL);
            end
            PH_NIB_LOW: begin
               if (!st[ST_ACK_BIT]) begin
                  // nibble = {~BUSY, PE, SELECT, nERROR}
                  nib = {~st[7], st[5], st[4], st[3]};
                  if (m_second) m_hi = nib;
                  else m_lo = nib;
                  m_ctrl  = CT_NONE;
                  m_phase = PH_NIB_HIGH;
                  m_timer = '0;
               end else if (count_miss(r_nib_to)) begin
                  close_sequence(END_NIB_TO);
               end
            end
            PH_NIB_HIGH: begin
               if (st[ST_ACK_BIT]) begin
                  if (!m_second) begin
                     m_second = 1'b1;
                     m_ctrl   = CT_FEED;
                     m_phase  = PH_NIB_LOW;
                     m_timer  = '0;
                  end else begin
                     v.valid = 1'b1;
                     v.value = {m_hi, m_lo};
                     m_count = m_count + 1'b1;
                     start_byte_read();
                  end
               end else if (count_miss(r_nib_to)) begin
                  close_sequence(END_NIB_TO);
               end
            end
            default: m_phase = PH_IDLE;
         endcase
      end
      v.ctrl   = m_ctrl;
      v.data   = m_data;
      v.count  = m_count;
      v.active = (m_phase != PH_IDLE);
      v.ecode  = m_end;
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Peripheral side: status samples chosen from the current phase
   // ---------------------------------------------------------------
   function automatic logic [7:0] off_pattern(input logic [7:0] r, input logic [7:0] want);
      logic [7:0] s;
      s = r;
      if ($urandom_range(3) == 0) s = 8'h00;
      if ((s & ST_MASK) == want) s = s ^ 8'h80;
      return s;
   endfunction

   function automatic logic [7:0] device_status(input bit good);
      logic [7:0] r;
      r = 8'($urandom_range(255));
      case (m_phase)
         PH_READY1, PH_READY2: r[ST_BUSY_BIT] = !good;
         PH_NEG1:     r = good ? (NEG1_WANT | (r & ~ST_MASK)) : off_pattern(r, NEG1_WANT);
         PH_NEG2:     r = good ? (NEG2_WANT | (r & ~ST_MASK)) : off_pattern(r, NEG2_WANT);
         PH_NIB_LOW:  r[ST_ACK_BIT] = !good;
         PH_NIB_HIGH: r[ST_ACK_BIT] = good;
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Mismatch reporting and response checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("ERROR %0t response %0d %s: got 0x%0h expected 0x%0h",
                  $time, rsp_count, what, got, want);
   endtask

   // Hold-off counter: runs down one per cycle once loaded
   always @(posedge clock) begin
      if (hold_off_cycles != 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   // Receiver: random stalls, held off while the counter runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles != 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 6);
      end
   end

   always @(posedge clock) begin : check_responses
      host_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_views.size() == 0) begin
            report_mismatch("response with none expected", rsp_tdata[31:0], '0);
         end else begin
            want = expected_views.pop_front();
            if (rsp_tdata[4:0] !== want.ctrl)
               report_mismatch("control_lines", rsp_tdata[4:0], want.ctrl);
            if (rsp_tdata[12:5] !== want.data)
               report_mismatch("data_lines", rsp_tdata[12:5], want.data);
            if (rsp_tuser !== want.valid)
               report_mismatch("byte_valid", rsp_tuser, want.valid);
            if (rsp_tdata[20:13] !== want.value)
               report_mismatch("byte_value", rsp_tdata[20:13], want.value);
            if (rsp_tdata[36:21] !== want.count)
               report_mismatch("bytes_received", rsp_tdata[36:21], want.count);
            if (rsp_tdata[37] !== want.active)
               report_mismatch("active", rsp_tdata[37], want.active);
            if (rsp_tdata[40:38] !== want.ecode)
               report_mismatch("end_code", rsp_tdata[40:38], want.ecode);
            if (rsp_tdata[47:41] !== 7'd0)
               report_mismatch("pad bits", rsp_tdata[47:41], 0);
            if (want.valid) bytes_seen++;
         end
      end
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_views.size());
         $display("FAIL parallel_nibble_mode_host_unit");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   // Offers one request, waits for it to be taken, then logs the
   // expected response. tvalid stays high for back-to-back requests.
   task automatic send_request(input action_type act, input logic [7:0] status);
      bit was_active;
      while (!no_idle && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= status;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      was_active = (m_phase != PH_IDLE);
      if (act == ACT_START && !was_active) sequences_run++;
      expected_views.push_back(predict_host_step(act, status));
      if (was_active && m_phase == PH_IDLE) end_seen[m_end]++;
   endtask

   // Feed status until the sequencer reaches stop_at (or idle). Bad
   // samples and ignored starts are mixed in at the given rates.
   task automatic drive_to(input phase_type stop_at, input int good_pct,
                           input int start_noise_pct);
      while (m_phase != PH_IDLE && m_phase != stop_at) begin
         if ($urandom_range(99) < start_noise_pct)
            send_request(ACT_START, 8'($urandom_range(255)));
         send_request(ACT_TICK, device_status($urandom_range(99) < good_pct));
      end
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [23:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_REQUEST_BYTE: r_req      = value[7:0];
         REG_BYTE_LIMIT:   r_limit    = value[15:0];
         REG_RESET_HOLD:   r_hold     = value;
         REG_READY_TO:     r_ready_to = value;
         REG_NEG_TO:       r_neg_to   = value;
         REG_STROBE:       r_strobe   = value;
         REG_NIBBLE_TO:    r_nib_to   = value;
         default: ;
      endcase
   endtask

   // Only called with the sequencer idle and nothing in flight
   task automatic apply_settings(input logic [7:0] req_byte, input logic [15:0] limit,
                                 input logic [23:0] hold, input logic [23:0] ready_to,
                                 input logic [23:0] neg_to, input logic [23:0] strobe,
                                 input logic [23:0] nib_to);
      wait_for_responses();
      write_reg(REG_REQUEST_BYTE, {16'd0, req_byte});
      write_reg(REG_BYTE_LIMIT, {8'd0, limit});
      write_reg(REG_RESET_HOLD, hold);
      write_reg(REG_READY_TO, ready_to);
      write_reg(REG_NEG_TO, neg_to);
      write_reg(REG_STROBE, strobe);
      write_reg(REG_NIBBLE_TO, nib_to);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Idle ticks on reset state, then one full clean read with the
   // widest timeouts, zero hold/strobe (behave as one), one byte.
   task automatic test_clean_transfer();
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_TICK, 8'hFF);
      apply_settings(8'hFF, 16'd1, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
      send_request(ACT_START, 8'h00);
      send_request(ACT_START, 8'hFF);      // start while running: ignored
      drive_to(PH_IDLE, 100, 0);
   endtask

   // Byte limit zero: ends as limit reached right after negotiation
   task automatic test_zero_limit();
      apply_settings(8'h00, 16'd0, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
      send_request(ACT_START, 8'h00);
      drive_to(PH_IDLE, 100, 0);
   endtask

   // One failure per wait type, with the tightest timeouts
   task automatic test_timeouts();
      apply_settings(8'h5A, 16'd1, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0);
      // BUSY stuck high on the second ready wait
      send_request(ACT_START, 8'h00);
      drive_to(PH_READY2, 100, 0);
      send_request(ACT_TICK, 8'h80);
      // first negotiation check against an all-zero sample
      send_request(ACT_START, 8'h00);
      drive_to(PH_NEG1, 100, 0);
      send_request(ACT_TICK, 8'h00);
      // second negotiation check, near miss on the pattern
      send_request(ACT_START, 8'h00);
      drive_to(PH_NEG2, 100, 0);
      send_request(ACT_TICK, 8'h58);
      // nAck never returns high: read ends with the count so far
      send_request(ACT_START, 8'h00);
      drive_to(PH_NIB_HIGH, 100, 0);
      send_request(ACT_TICK, 8'h00);
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      apply_settings(8'hA5, 16'd10, 24'd1, 24'd3, 24'd3, 24'd1, 24'd3);
      hold_off_cycles <= 120;
      send_request(ACT_START, 8'h00);
      drive_to(PH_IDLE, 90, 0);
   endtask

   // Mostly well-formed peripherals with random content and settings,
   // mixed with bad samples, ignored starts and idle noise.
   task automatic test_random_sequences();
      int goal, t;
      logic [23:0] nib, rdy, neg;
      logic [15:0] lim;
      goal = requests_sent + 740;
      t = 0;
      while (requests_sent < goal) begin
         if (t == 0 || $urandom_range(2) == 0) begin
            nib = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom_range(6));
            rdy = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom_range(6));
            neg = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom_range(6));
            // big limits only where nibble timeouts can end the read soon
            if (nib == 24'hFFFFFF) lim = 16'($urandom_range(3));
            else if (nib <= 1 && $urandom_range(5) == 0) lim = 16'hFFFF;
            else lim = 16'($urandom_range(6));
            apply_settings(8'($urandom_range(255)), lim, 24'($urandom_range(5)), rdy, neg,
                           24'($urandom_range(5)), nib);
         end
         no_idle <= (t >= 8 && t < 14);
         repeat ($urandom_range(2)) send_request(ACT_TICK, 8'($urandom_range(255)));
         send_request(ACT_START, 8'($urandom_range(255)));
         drive_to(PH_IDLE, $urandom_range(70, 97), 3);
         t++;
      end
      no_idle <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      r_req      = RST_REQUEST_BYTE;
      r_limit    = RST_BYTE_LIMIT;
      r_hold     = RST_RESET_HOLD;
      r_ready_to = RST_READY_TO;
      r_neg_to   = RST_NEG_TO;
      r_strobe   = RST_STROBE;
      r_nib_to   = RST_NIBBLE_TO;
      m_phase    = PH_IDLE;
      m_end      = END_NONE;
      m_timer    = '0;
      m_ctrl     = CT_NONE;
      m_data     = '0;
      m_lo       = '0;
      m_hi       = '0;
      m_second   = 1'b0;
      m_count    = '0;
      foreach (end_seen[i]) end_seen[i] = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_clean_transfer();
      test_zero_limit();
      test_timeouts();
      test_backpressure();
      test_random_sequences();

      wait_for_responses();
      repeat (4) @(posedge clock);

      $display("ran %0d requests over %0d sequences, %0d responses, %0d bytes read",
               requests_sent, sequences_run, rsp_count, bytes_seen);
      $display("endings: limit %0d, nibble timeout %0d, not ready %0d, neg1 %0d, neg2 %0d",
               end_seen[END_LIMIT], end_seen[END_NIB_TO], end_seen[END_NOT_READY],
               end_seen[END_NEG1_FAIL], end_seen[END_NEG2_FAIL]);
      if (mismatch_count == 0 && expected_views.size() == 0) begin
         $display("PASS parallel_nibble_mode_host_unit");
      end else begin
         $display("FAIL parallel_nibble_mode_host_unit");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pnmh_pkg.sv
rtl/core/parallel_nibble_mode_host_unit.sv
tb/tb_parallel_nibble_mode_host_unit.sv
